>>> rtl/core/sha1_pkg.sv
// sha1_pkg: shared constants, types and helper functions for the sha-1 digest core
// no dependencies; imported by sha1_front, sha1_back and sha1_message_digest_top
package sha1_pkg;

  localparam int LENGTH_BITS = 64;
  localparam int ROUNDS      = 80;
  localparam int QDEPTH      = 4;
  localparam int QADDR_W     = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // initial chaining words
  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // round constants, one per group of twenty rounds
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] PAD_WORD = 32'h80000000;

  // kind of a queued word
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_LAST_FULL = 2'd1,
    KIND_LAST_PART = 2'd2
  } kind_t;

  // one entry of the queue between the front and the back
  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;
    logic [5:0]  add_bits;
  } q_entry_t;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

endpackage

>>> rtl/core/sha1_front.sv
// sha1_front: accepts message words, trims and pads a final word, counts its bits
// and holds the result in a small queue for the back end; uses sha1_pkg
module sha1_front import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] message_word, [34:32] valid_bytes, [39:35] zero
  input  logic        in_tlast,   // last_word
  output logic        q_valid,
  input  logic        q_ready,
  output q_entry_t    q_entry
);

  q_entry_t            mem_r [QDEPTH];
  logic [QADDR_W-1:0]  wr_ptr_r;
  logic [QADDR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [2:0]          vb_eff;
  logic [31:0]         word_in;
  q_entry_t            entry_nxt;
  logic                wr_en;
  logic                rd_en;

  assign word_in = in_tdata[31:0];

  // clamp valid byte count to a full word
  assign vb_eff = (in_tdata[34:32] > 3'd4) ? 3'd4 : in_tdata[34:32];

  // classify the transaction and build the word to store
  always_comb begin
    entry_nxt.kind     = KIND_DATA;
    entry_nxt.word     = word_in;
    entry_nxt.add_bits = 6'd32;
    if (in_tlast) begin
      entry_nxt.add_bits = {vb_eff, 3'b000};
      case (vb_eff)
        3'd0: begin
          entry_nxt.kind = KIND_LAST_PART;
          entry_nxt.word = PAD_WORD;
        end
        3'd1: begin
          entry_nxt.kind = KIND_LAST_PART;
          entry_nxt.word = {word_in[31:24], 24'h800000};
        end
        3'd2: begin
          entry_nxt.kind = KIND_LAST_PART;
          entry_nxt.word = {word_in[31:16], 16'h8000};
        end
        3'd3: begin
          entry_nxt.kind = KIND_LAST_PART;
          entry_nxt.word = {word_in[31:8], 8'h80};
        end
        default: begin
          entry_nxt.kind = KIND_LAST_FULL;
          entry_nxt.word = word_in;
        end
      endcase
    end
  end

  // queue handshakes
  assign in_tready = (count_r != QCNT_W'(QDEPTH));
  assign q_valid   = (count_r != '0);
  assign q_entry   = mem_r[rd_ptr_r];
  assign wr_en     = in_tvalid && in_tready;
  assign rd_en     = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= entry_nxt;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/sha1_back.sv
// sha1_back: block buffer, padding sequencer, 80-round compression and digest output
// uses sha1_pkg; fed by sha1_front through its queue
module sha1_back import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  q_entry_t    q_entry,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        out_tlast   // last_of_digest
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_80,
    PH_ZERO,
    PH_LENLO,
    PH_DONE
  } phase_t;

  state_t                 state_r;
  phase_t                 ph_r;
  logic                   pad_act_r;
  logic [31:0]            chain_r [5];
  logic [31:0]            a_r, b_r, c_r, d_r, e_r;
  logic [31:0]            w_r [16];
  logic [3:0]             pos_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic [6:0]             rnd_r;
  logic [2:0]             idx_r;

  logic        push_en;
  logic [31:0] push_word;
  logic [31:0] w_nxt;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] a_nxt;
  logic        shift_en;
  logic [31:0] shift_in;
  logic        out_done;

  assign q_ready    = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {5'b00000, idx_r, chain_r[0]};
  assign out_tlast  = (idx_r == 3'd4);
  assign out_done   = out_tvalid && out_tready && out_tlast;

  // word pushed into the block buffer: from the queue or from the padding sequence
  always_comb begin
    push_en   = 1'b0;
    push_word = q_entry.word;
    if (state_r == ST_IDLE) begin
      push_en = q_valid;
    end else if (state_r == ST_PAD) begin
      push_en = 1'b1;
      case (ph_r)
        PH_80:    push_word = PAD_WORD;
        PH_ZERO:  push_word = (pos_r == 4'd14) ? len_r[63:32] : 32'h0;
        PH_LENLO: push_word = len_r[31:0];
        default:  push_word = 32'h0;
      endcase
    end
  end

  // message schedule word of the current round
  assign w_nxt = (rnd_r < 7'd16) ? w_r[0] : rotl1(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0]);

  // round function and constant
  always_comb begin
    if (rnd_r < 7'd20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K0;
    end else if (rnd_r < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K1;
    end else if (rnd_r < 7'd60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K3;
    end
  end

  assign a_nxt = rotl5(a_r) + f_val + e_r + k_val + w_nxt;

  // block buffer shifts on a push and once per round
  assign shift_en = push_en || (state_r == ST_COMP);
  assign shift_in = (state_r == ST_COMP) ? w_nxt : push_word;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= shift_in;
    end
  end

  // sequencer, chaining words and working variables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ph_r      <= PH_DONE;
      pad_act_r <= 1'b0;
      pos_r     <= '0;
      len_r     <= '0;
      rnd_r     <= '0;
      idx_r     <= '0;
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= H_INIT[i];
      end
    end else begin
      // common push bookkeeping; a full buffer starts a compression
      if (push_en) begin
        pos_r <= pos_r + 1'b1;
        if (pos_r == 4'd15) begin
          rnd_r <= '0;
          a_r   <= chain_r[0];
          b_r   <= chain_r[1];
          c_r   <= chain_r[2];
          d_r   <= chain_r[3];
          e_r   <= chain_r[4];
        end
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            len_r <= len_r + LENGTH_BITS'(q_entry.add_bits);
            if (q_entry.kind == KIND_LAST_FULL) begin
              pad_act_r <= 1'b1;
              ph_r      <= PH_80;
            end else if (q_entry.kind == KIND_LAST_PART) begin
              pad_act_r <= 1'b1;
              ph_r      <= PH_ZERO;
            end
            if (pos_r == 4'd15) begin
              state_r <= ST_COMP;
            end else if (q_entry.kind != KIND_DATA) begin
              state_r <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          case (ph_r)
            PH_80:    ph_r <= PH_ZERO;
            PH_ZERO:  ph_r <= (pos_r == 4'd14) ? PH_LENLO : PH_ZERO;
            PH_LENLO: ph_r <= PH_DONE;
            default:  ph_r <= PH_DONE;
          endcase
          if (pos_r == 4'd15) begin
            state_r <= ST_COMP;
          end
        end
        ST_COMP: begin
          e_r   <= d_r;
          d_r   <= c_r;
          c_r   <= rotl30(b_r);
          b_r   <= a_r;
          a_r   <= a_nxt;
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == 7'(ROUNDS - 1)) begin
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          chain_r[4] <= chain_r[4] + e_r;
          if (!pad_act_r) begin
            state_r <= ST_IDLE;
          end else if (ph_r == PH_DONE) begin
            state_r <= ST_OUT;
            idx_r   <= '0;
          end else begin
            state_r <= ST_PAD;
          end
        end
        ST_OUT: begin
          // digest leaves from chain word zero; the others move up
          if (out_tready) begin
            idx_r <= idx_r + 1'b1;
            if (out_tlast) begin
              for (int i = 0; i < 5; i++) begin
                chain_r[i] <= H_INIT[i];
              end
              len_r     <= '0;
              pos_r     <= '0;
              pad_act_r <= 1'b0;
              ph_r      <= PH_DONE;
              state_r   <= ST_IDLE;
            end else begin
              for (int i = 0; i < 4; i++) begin
                chain_r[i] <= chain_r[i+1];
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // the buffer is empty whenever a digest is being sent
  a_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (pos_r == 4'd0))
    else $error("digest output with a partly filled block");

  // a finished digest restores the initial state
  a_out_reset: assert property (@(posedge clk) disable iff (!rst_n)
    out_done |=> (chain_r[0] == H_INIT[0]) && (len_r == '0) && (state_r == ST_IDLE))
    else $error("state not restored after digest");

  // a sixteenth word always starts a compression
  a_full_comp: assert property (@(posedge clk) disable iff (!rst_n)
    (push_en && (pos_r == 4'd15)) |=> (state_r == ST_COMP) && (rnd_r == 7'd0))
    else $error("full block did not start compression");

  // round counter stays in range while compressing
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP) |-> (rnd_r < 7'(ROUNDS)))
    else $error("round counter out of range");

endmodule

>>> rtl/core/sha1_message_digest_top.sv
// sha1_message_digest_top: sha-1 digest core, front end and back end joined by a queue
// depends on sha1_pkg, sha1_front and sha1_back
//
//   channel  | direction | payload
//   in_      | slave     | tdata: message_word, valid_bytes; tlast: last_word
//   out_     | master    | tdata: digest_word, word_index; tlast: last_of_digest
//
// message words enter the block buffer one per cycle while the back end is idle; every
// full block then occupies the single round unit for all 80 rounds and then the chaining
// add. a final word is followed by pad words, possibly a second block, and the five
// digest words. the front queue holds four words and keeps accepting, until it is full,
// while the back end compresses or waits on out_tready.
// reset (rst_n low, synchronous) restores the initial chaining words and empties the queue.
module sha1_message_digest_top import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] message_word, [34:32] valid_bytes, [39:35] zero
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        out_tlast   // last_of_digest
);

  logic     q_valid;
  logic     q_ready;
  q_entry_t q_entry;

  // front end: classify and queue message words
  sha1_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry)
  );

  // back end: padding, compression and digest output
  sha1_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_entry    (q_entry),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
